// File: hdl/xibe_pkg.sv
// Shared types and constants of the x86-64 instruction byte encoder.
package xibe_pkg;

  localparam int MAX_BYTES = 11;
  localparam int LEN_W     = 4;

  typedef enum logic [4:0] {
    CMD_MOV_IMM    = 5'd0,
    CMD_STORE_SLOT = 5'd1,
    CMD_LOAD_SLOT  = 5'd2,
    CMD_MOV_RR     = 5'd3,
    CMD_ALU_SLOT   = 5'd4,
    CMD_GRP_SLOT   = 5'd5,
    CMD_CALL_SLOT  = 5'd6,
    CMD_CMP_IMM    = 5'd7,
    CMD_SETCC      = 5'd8,
    CMD_PUSH       = 5'd9,
    CMD_POP        = 5'd10,
    CMD_JZ         = 5'd11,
    CMD_JMP        = 5'd12,
    CMD_RET        = 5'd13,
    CMD_LOAD_RAX   = 5'd14,
    CMD_STORE_RAX  = 5'd15,
    CMD_SUB_RSP    = 5'd16
  } cmd_t;

  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_AND = 3'd2;
  localparam logic [2:0] ALU_OR  = 3'd3;
  localparam logic [2:0] ALU_CMP = 3'd4;

  localparam logic [2:0] GRP_NOT  = 3'd0;
  localparam logic [2:0] GRP_MUL  = 3'd1;
  localparam logic [2:0] GRP_IDIV = 3'd2;
  localparam logic [2:0] GRP_SAR  = 3'd3;
  localparam logic [2:0] GRP_SHL  = 3'd4;
  localparam logic [2:0] GRP_LEA  = 3'd5;

  localparam logic [2:0] CC_EQ = 3'd0;
  localparam logic [2:0] CC_NE = 3'd1;
  localparam logic [2:0] CC_GT = 3'd2;
  localparam logic [2:0] CC_LT = 3'd3;
  localparam logic [2:0] CC_GE = 3'd4;
  localparam logic [2:0] CC_LE = 3'd5;

  localparam logic [7:0] REX_W    = 8'h48;
  localparam logic [7:0] OP_MOVI  = 8'hB8;
  localparam logic [7:0] OP_MOVST = 8'h89;
  localparam logic [7:0] OP_MOVLD = 8'h8B;
  localparam logic [7:0] OP_ESC   = 8'h0F;
  localparam logic [7:0] OP_JZ    = 8'h84;
  localparam logic [7:0] OP_GRP1  = 8'h81;
  localparam logic [7:0] OP_GRP3  = 8'hF7;
  localparam logic [7:0] OP_SHIFT = 8'hD3;
  localparam logic [7:0] OP_LEA   = 8'h8D;
  localparam logic [7:0] OP_GRP5  = 8'hFF;
  localparam logic [7:0] OP_POP   = 8'h8F;
  localparam logic [7:0] OP_JMP   = 8'hE9;
  localparam logic [7:0] OP_RET   = 8'hC3;

  // one fully encoded instruction, byte 0 in the low bits
  typedef struct packed {
    logic [8*MAX_BYTES-1:0] bytes;
    logic [LEN_W-1:0]       len;
    logic                   bad;
  } instr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/xibe_front.sv
// Front end: accepts a request and encodes it into a complete instruction.
module xibe_front
  import xibe_pkg::*;
(
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  command,
  input  logic [3:0]  first_reg,
  input  logic [3:0]  second_reg,
  input  logic [2:0]  variant,
  input  logic [30:0] slot_offset,
  input  logic [63:0] immediate,
  input  q_stat_t     q_stat,
  output logic        q_push,
  output instr_t      q_instr
);

  logic [7:0]       b [MAX_BYTES];
  logic [LEN_W-1:0] n;
  logic             bad;
  logic [31:0]      disp;
  logic [2:0]       ext;
  logic [7:0]       op;
  logic [31:0]      imm_lo;
  logic [31:0]      imm_hi;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  assign disp   = 32'd0 - {1'b0, slot_offset} - 32'd8;
  assign imm_lo = immediate[31:0];
  assign imm_hi = immediate[63:32];

  always_comb begin
    for (int k = 0; k < MAX_BYTES; k++) b[k] = 8'h00;
    n   = '0;
    bad = 1'b0;
    ext = 3'd0;
    op  = 8'h00;

    // operation and ModR/M extension for the table-driven forms
    case (command)
      CMD_ALU_SLOT: begin
        case (variant)
          ALU_ADD: op = 8'h01;
          ALU_SUB: op = 8'h29;
          ALU_AND: op = 8'h21;
          ALU_OR:  op = 8'h09;
          ALU_CMP: op = 8'h39;
          default: bad = 1'b1;
        endcase
      end
      CMD_GRP_SLOT: begin
        case (variant)
          GRP_NOT:  begin op = OP_GRP3;  ext = 3'd2; end
          GRP_MUL:  begin op = OP_GRP3;  ext = 3'd4; end
          GRP_IDIV: begin op = OP_GRP3;  ext = 3'd7; end
          GRP_SAR:  begin op = OP_SHIFT; ext = 3'd7; end
          GRP_SHL:  begin op = OP_SHIFT; ext = 3'd4; end
          GRP_LEA:  begin op = OP_LEA;   ext = 3'd0; end
          default:  bad = 1'b1;
        endcase
      end
      CMD_SETCC: begin
        case (variant)
          CC_EQ:   op = 8'h94;
          CC_NE:   op = 8'h95;
          CC_GT:   op = 8'h9F;
          CC_LT:   op = 8'h9C;
          CC_GE:   op = 8'h9D;
          CC_LE:   op = 8'h9E;
          default: bad = 1'b1;
        endcase
      end
      CMD_STORE_SLOT, CMD_LOAD_SLOT: ext = first_reg[2:0];
      CMD_CALL_SLOT:                 ext = 3'd2;
      CMD_CMP_IMM:                   ext = 3'd7;
      default:                       ext = 3'd0;
    endcase

    case (command)
      CMD_MOV_IMM: begin
        b[0] = REX_W | {7'd0, first_reg[3]};
        b[1] = OP_MOVI | {5'd0, first_reg[2:0]};
        b[2] = imm_lo[7:0];   b[3] = imm_lo[15:8];
        b[4] = imm_lo[23:16]; b[5] = imm_lo[31:24];
        b[6] = imm_hi[7:0];   b[7] = imm_hi[15:8];
        b[8] = imm_hi[23:16]; b[9] = imm_hi[31:24];
        n = LEN_W'(10);
      end
      CMD_STORE_SLOT, CMD_LOAD_SLOT, CMD_ALU_SLOT, CMD_GRP_SLOT, CMD_SETCC,
      CMD_CMP_IMM: begin
        case (command)
          CMD_STORE_SLOT: begin b[0] = REX_W | {5'd0, first_reg[3], 2'd0}; b[1] = OP_MOVST; end
          CMD_LOAD_SLOT:  begin b[0] = REX_W | {5'd0, first_reg[3], 2'd0}; b[1] = OP_MOVLD; end
          CMD_SETCC:      begin b[0] = OP_ESC; b[1] = op; end
          CMD_CMP_IMM:    begin b[0] = REX_W;  b[1] = OP_GRP1; end
          default:        begin b[0] = REX_W;  b[1] = op; end
        endcase
        b[2] = {2'b10, ext, 3'b101};
        b[3] = disp[7:0];   b[4] = disp[15:8];
        b[5] = disp[23:16]; b[6] = disp[31:24];
        b[7] = imm_lo[7:0];   b[8]  = imm_lo[15:8];
        b[9] = imm_lo[23:16]; b[10] = imm_lo[31:24];
        n = (command == CMD_CMP_IMM) ? LEN_W'(11) : LEN_W'(7);
      end
      CMD_MOV_RR: begin
        b[0] = REX_W | {5'd0, second_reg[3], 1'b0, first_reg[3]};
        b[1] = OP_MOVST;
        b[2] = {2'b11, second_reg[2:0], first_reg[2:0]};
        n = LEN_W'(3);
      end
      CMD_CALL_SLOT: begin
        b[0] = OP_GRP5;
        b[1] = {2'b10, ext, 3'b101};
        b[2] = disp[7:0];   b[3] = disp[15:8];
        b[4] = disp[23:16]; b[5] = disp[31:24];
        n = LEN_W'(6);
      end
      CMD_PUSH: begin
        b[0] = REX_W | {7'd0, first_reg[3]};
        b[1] = OP_GRP5;
        b[2] = {2'b11, 3'd6, first_reg[2:0]};
        n = LEN_W'(3);
      end
      CMD_POP: begin
        b[0] = REX_W | {7'd0, first_reg[3]};
        b[1] = OP_POP;
        b[2] = {2'b11, 3'd0, first_reg[2:0]};
        n = LEN_W'(3);
      end
      CMD_JZ: begin
        b[0] = OP_ESC;
        b[1] = OP_JZ;
        b[2] = imm_lo[7:0];   b[3] = imm_lo[15:8];
        b[4] = imm_lo[23:16]; b[5] = imm_lo[31:24];
        n = LEN_W'(6);
      end
      CMD_JMP: begin
        b[0] = OP_JMP;
        b[1] = imm_lo[7:0];   b[2] = imm_lo[15:8];
        b[3] = imm_lo[23:16]; b[4] = imm_lo[31:24];
        n = LEN_W'(5);
      end
      CMD_RET: begin
        b[0] = OP_RET;
        n = LEN_W'(1);
      end
      CMD_LOAD_RAX: begin
        b[0] = REX_W; b[1] = OP_MOVLD; b[2] = 8'h00;
        n = LEN_W'(3);
      end
      CMD_STORE_RAX: begin
        b[0] = REX_W; b[1] = OP_MOVST; b[2] = 8'h38;
        n = LEN_W'(3);
      end
      CMD_SUB_RSP: begin
        b[0] = REX_W; b[1] = OP_GRP1; b[2] = 8'hEC;
        b[3] = imm_lo[7:0];   b[4] = imm_lo[15:8];
        b[5] = imm_lo[23:16]; b[6] = imm_lo[31:24];
        n = LEN_W'(7);
      end
      default: bad = 1'b1;
    endcase

    // rejected request: a single flagged zero byte
    if (bad) begin
      for (int k = 0; k < MAX_BYTES; k++) b[k] = 8'h00;
      n = LEN_W'(1);
    end

    for (int k = 0; k < MAX_BYTES; k++) q_instr.bytes[8*k +: 8] = b[k];
    q_instr.len = n;
    q_instr.bad = bad;
  end

endmodule

// File: hdl/xibe_queue.sv
// Small register FIFO between the encoder front end and the byte sequencer.
module xibe_queue
  import xibe_pkg::*;
#(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: hdl/xibe_back.sv
// Back end: shifts one encoded instruction out a byte per cycle, unless stalled, into the output register.
module xibe_back
  import xibe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  instr_t     q_instr,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] code_byte,
  output logic       last_byte,
  output logic       bad_request
);

  logic                   busy;
  logic [8*MAX_BYTES-1:0] sh;
  logic [LEN_W-1:0]       remain;
  logic                   bad;
  logic                   out_adv;
  logic                   at_last;

  assign out_adv = !out_valid || !out_stall;
  assign at_last = (remain == LEN_W'(1));
  // refill on the cycle the last byte moves out, so instructions run gap-free
  assign q_pop   = q_valid && (!busy || (out_adv && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_adv) out_valid <= busy;
      if (q_pop) begin
        busy <= 1'b1;
      end else if (out_adv && busy && at_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && busy) begin
      code_byte   <= sh[7:0];
      last_byte   <= at_last;
      bad_request <= bad;
    end
    if (q_pop) begin
      sh     <= q_instr.bytes;
      remain <= q_instr.len;
      bad    <= q_instr.bad;
    end else if (out_adv && busy) begin
      sh     <= sh >> 8;
      remain <= remain - LEN_W'(1);
    end
  end

endmodule

// File: hdl/x64_instruction_byte_encoder_unit.sv
// Top level of the x86-64 instruction byte encoder.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    command first_reg second_reg variant slot_offset immediate
//  out      out  out_valid/out_stall  code_byte last_byte bad_request
//
// An instruction of L bytes (1 to 11) leaves one byte at a time; bytes of consecutive queued
// instructions follow without gaps, one byte per cycle unless out_stall holds them, set by the
// back-end byte shifter. The first byte passes the queue, shifter and output registers.
// The queue holds QUEUE_DEPTH encoded instructions; in_stall rises when it fills.
// Synchronous reset empties the queue and drops any byte in flight.
module x64_instruction_byte_encoder_unit
  import xibe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  command,
  input  logic [3:0]  first_reg,
  input  logic [3:0]  second_reg,
  input  logic [2:0]  variant,
  input  logic [30:0] slot_offset,
  input  logic [63:0] immediate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  code_byte,
  output logic        last_byte,
  output logic        bad_request
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  instr_t  push_instr;
  instr_t  pop_instr;

  xibe_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .first_reg   (first_reg),
    .second_reg  (second_reg),
    .variant     (variant),
    .slot_offset (slot_offset),
    .immediate   (immediate),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_instr     (push_instr)
  );

  xibe_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(instr_t))
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_instr),
    .pop       (q_pop),
    .pop_data  (pop_instr),
    .stat      (q_stat)
  );

  xibe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (!q_stat.empty),
    .q_instr     (pop_instr),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_byte   (code_byte),
    .last_byte   (last_byte),
    .bad_request (bad_request)
  );

  a_bad_single_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_request |-> last_byte && code_byte == 8'h00)
    else $error("flagged byte is not a single zero byte");

  a_no_midgap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_byte |=> out_valid)
    else $error("gap inside an instruction");

  a_queue_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !in_stall)
    else $error("input stalled while queue empty");

endmodule
